@@ rtl/stpg_pkg.sv @@
// Package for the step/dir pulse generator: request and status codes,
// register indexes, controller states and the widths of the period divider.
// No dependencies.
package stpg_pkg;

  // Request kinds carried in the input tuser
  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_START = 3'd1,
    REQ_STOP  = 3'd2,
    REQ_FAULT = 3'd3,
    REQ_CLEAR = 3'd4
  } req_t;

  // Move start status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_BUSY  = 2'd1,
    STAT_FAULT = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } state_t;

  // Configuration register indexes
  localparam logic CFG_TICK_RATE  = 1'b0;
  localparam logic CFG_MICROSTEPS = 1'b1;

  // Register and field widths
  localparam int unsigned TICK_W  = 20;
  localparam int unsigned MICRO_W = 9;
  localparam int unsigned RPM_W   = 12;
  localparam int unsigned STEPS_W = 32;

  // Numerator: tick_rate * 60; denominator: rpm * microsteps * 2
  localparam int unsigned NUM_W  = TICK_W + 6;
  localparam int unsigned PROD_W = RPM_W + MICRO_W;
  localparam int unsigned DEN_W  = PROD_W + 1;
  localparam int unsigned CNT_W  = $clog2(NUM_W);

  localparam logic [NUM_W-1:0] SECS_PER_MIN = NUM_W'(60);

endpackage

@@ rtl/stpg_div.sv @@
// Bit-serial restoring divider for the edge period: one quotient bit per
// cycle, numerator shifted out MSB first, quotient shifted in at the LSB end.
// Depends on stpg_pkg.
module stpg_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [stpg_pkg::NUM_W-1:0] num,
  input  logic [stpg_pkg::DEN_W-1:0] den,
  output logic                       done,
  output logic [stpg_pkg::NUM_W-1:0] quo
);
  import stpg_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Trial subtract of one shifted-in numerator bit
  assign trial = {rem_r, num_r[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W - 1);
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      num_nxt = {num_r[NUM_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Shift registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ rtl/stepper_step_pulse_generator.sv @@
// Step/dir pulse generator for one stepper axis: request decode, pin state,
// tick counter and move control. Depends on stpg_pkg and stpg_div.
//
// Channel   Dir  Handshake            Content
// in_       in   tvalid/tready        tuser: req_type; tdata: request fields
// out_      out  tvalid/tready        tdata: status, pin levels, pulses, count
// cfg_      in   wr_en only           register index and write data
//
// Tick, stop, fault, clear, unknown and refused start requests need no divider;
// the result is ready the cycle after acceptance. A move start that passes the
// busy and fault checks runs the bit-serial period divider, one bit per cycle,
// before its result.
// Reset (rst_n low, synchronous) clears all axis state and loads the default
// register values. Further requests are held off while a result waits and the
// output is stalled; one request is in work at a time.
module stepper_step_pulse_generator #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // tdata: move_steps[31:0], speed_rpm[43:32], direction_cw[44],
  //        fault_pin_low[45], zero pad [47:46]
  input  logic [47:0] in_tdata,
  // tuser: req_type[2:0]
  input  logic [2:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: status[1:0], step_level[2], enable_level[3], dir_level[4],
  //        moving[5], fault_latched_out[6], move_done[7], fault_flagged[8],
  //        steps_completed[40:9], zero pad [47:41]
  output logic [47:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [19:0] cfg_wdata
);
  import stpg_pkg::*;

  // Configuration registers
  logic [TICK_W-1:0]  tick_rate_r;
  logic [MICRO_W-1:0] micro_r;

  // Axis state
  logic                   running_r, running_nxt;
  logic                   step_r, step_nxt;
  logic                   enable_r, enable_nxt;
  logic                   dir_r, dir_nxt;
  logic                   fault_r, fault_nxt;
  logic [STEPS_W-1:0]     target_r, target_nxt;
  logic [STEPS_W-1:0]     done_cnt_r, done_cnt_nxt;
  logic [COUNT_WIDTH-1:0] period_r, period_nxt;
  logic [COUNT_WIDTH-1:0] tick_cnt_r, tick_cnt_nxt;
  logic [COUNT_WIDTH-1:0] tick_inc;
  logic [STEPS_W-1:0]     done_inc;

  // Pending move start
  logic [STEPS_W-1:0] pend_steps_r, pend_steps_nxt;
  logic [RPM_W-1:0]   pend_rpm_r, pend_rpm_nxt;
  logic               pend_dir_r, pend_dir_nxt;

  // Controller
  state_t state_r, state_nxt;
  logic   in_fire;
  logic   start_ok;
  req_t   req;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] status_r, status_nxt;
  logic       done_pulse_r, done_pulse_nxt;
  logic       fault_pulse_r, fault_pulse_nxt;
  logic       emit;
  logic       out_free;

  // Divider
  logic                   div_start;
  logic                   div_done;
  logic [NUM_W-1:0]       div_num;
  logic [DEN_W-1:0]       div_den;
  logic [NUM_W-1:0]       div_quo;
  logic [COUNT_WIDTH-1:0] quo_sat;
  logic                   den_zero;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign req       = req_t'(in_tuser);
  assign start_ok  = !running_r && !fault_r && !in_tdata[45];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_rate_r <= TICK_W'(100000);
      micro_r     <= MICRO_W'(16);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TICK_RATE:  tick_rate_r <= cfg_wdata[TICK_W-1:0];
        CFG_MICROSTEPS: micro_r     <= cfg_wdata[MICRO_W-1:0];
        default:        ;
      endcase
    end
  end

  // Period operands; the divider registers them on start
  assign div_num   = NUM_W'(tick_rate_r) * SECS_PER_MIN;
  assign div_den   = {PROD_W'(PROD_W'(pend_rpm_r) * PROD_W'(micro_r)), 1'b0};
  assign den_zero  = (pend_rpm_r == '0) || (micro_r == '0);
  assign div_start = (state_r == ST_LOAD);

  stpg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Saturate the quotient to the counter width
  generate
    if (COUNT_WIDTH >= NUM_W) begin : g_wide
      assign quo_sat = COUNT_WIDTH'(div_quo);
    end else begin : g_narrow
      assign quo_sat = (|div_quo[NUM_W-1:COUNT_WIDTH]) ? '1 : div_quo[COUNT_WIDTH-1:0];
    end
  endgenerate

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire && req == REQ_START && start_ok) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign tick_inc = tick_cnt_r + 1'b1;
  assign done_inc = done_cnt_r + 1'b1;

  // Axis state update and result
  always_comb begin
    running_nxt     = running_r;
    step_nxt        = step_r;
    enable_nxt      = enable_r;
    dir_nxt         = dir_r;
    fault_nxt       = fault_r;
    target_nxt      = target_r;
    done_cnt_nxt    = done_cnt_r;
    period_nxt      = period_r;
    tick_cnt_nxt    = tick_cnt_r;
    pend_steps_nxt  = pend_steps_r;
    pend_rpm_nxt    = pend_rpm_r;
    pend_dir_nxt    = pend_dir_r;
    status_nxt      = status_r;
    done_pulse_nxt  = done_pulse_r;
    fault_pulse_nxt = fault_pulse_r;
    emit            = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          emit            = 1'b1;
          status_nxt      = STAT_OK;
          done_pulse_nxt  = 1'b0;
          fault_pulse_nxt = 1'b0;
          unique case (req)
            REQ_TICK: begin
              if (running_r) begin
                if (tick_inc >= period_r) begin
                  tick_cnt_nxt = '0;
                  if (!step_r) begin
                    step_nxt = 1'b1;
                  end else begin
                    step_nxt     = 1'b0;
                    done_cnt_nxt = done_inc;
                    if (done_inc >= target_r) begin
                      running_nxt    = 1'b0;
                      enable_nxt     = 1'b0;
                      done_pulse_nxt = 1'b1;
                    end
                  end
                end else begin
                  tick_cnt_nxt = tick_inc;
                end
              end
            end
            REQ_START: begin
              if (running_r) begin
                status_nxt = STAT_BUSY;
              end else if (!start_ok) begin
                fault_nxt  = 1'b1;
                status_nxt = STAT_FAULT;
              end else begin
                // hold the request until the period is known
                emit           = 1'b0;
                pend_steps_nxt = in_tdata[31:0];
                pend_rpm_nxt   = in_tdata[43:32];
                pend_dir_nxt   = in_tdata[44];
              end
            end
            REQ_STOP: begin
              running_nxt    = 1'b0;
              step_nxt       = 1'b0;
              enable_nxt     = 1'b0;
              done_pulse_nxt = 1'b1;
            end
            REQ_FAULT: begin
              fault_nxt       = 1'b1;
              fault_pulse_nxt = 1'b1;
              if (running_r) begin
                running_nxt    = 1'b0;
                step_nxt       = 1'b0;
                enable_nxt     = 1'b0;
                done_pulse_nxt = 1'b1;
              end
            end
            REQ_CLEAR: fault_nxt = 1'b0;
            default: ;
          endcase
        end
      end
      ST_FIN: begin
        if (out_free) begin
          // start the move
          emit            = 1'b1;
          status_nxt      = STAT_OK;
          done_pulse_nxt  = 1'b0;
          fault_pulse_nxt = 1'b0;
          dir_nxt         = pend_dir_r;
          target_nxt      = pend_steps_r;
          done_cnt_nxt    = '0;
          tick_cnt_nxt    = '0;
          period_nxt      = den_zero ? '1 : quo_sat;
          step_nxt        = 1'b0;
          enable_nxt      = 1'b1;
          running_nxt     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  // Control and axis state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      running_r   <= 1'b0;
      step_r      <= 1'b0;
      enable_r    <= 1'b0;
      dir_r       <= 1'b0;
      fault_r     <= 1'b0;
      target_r    <= '0;
      done_cnt_r  <= '0;
      period_r    <= '0;
      tick_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      running_r   <= running_nxt;
      step_r      <= step_nxt;
      enable_r    <= enable_nxt;
      dir_r       <= dir_nxt;
      fault_r     <= fault_nxt;
      target_r    <= target_nxt;
      done_cnt_r  <= done_cnt_nxt;
      period_r    <= period_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_steps_r  <= pend_steps_nxt;
    pend_rpm_r    <= pend_rpm_nxt;
    pend_dir_r    <= pend_dir_nxt;
    status_r      <= status_nxt;
    done_pulse_r  <= done_pulse_nxt;
    fault_pulse_r <= fault_pulse_nxt;
  end

  // Levels are shown as they stand after the request
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, done_cnt_r, fault_pulse_r, done_pulse_r, fault_r,
                       running_r, dir_r, enable_r, step_r, status_r};

endmodule

@@ tb/stpg_tb_pkg.sv @@
// Shared constants for the step/dir pulse generator testbench: drain timing.
// No dependencies.
`timescale 1ns / 1ps
package stpg_tb_pkg;

  // Cycles to let pass once the last result is in
  localparam int unsigned SETTLE_CYCLES = 40;

endpackage

@@ tb/stpg_checker.sv @@
// Scoreboard for the step/dir pulse generator: tracks the axis state from the
// accepted requests and register writes, and checks every result field.
// Depends on stpg_pkg.
`timescale 1ns / 1ps
module stpg_checker #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // tdata: move_steps[31:0], speed_rpm[43:32], direction_cw[44],
  //        fault_pin_low[45], zero pad [47:46]
  input  logic [47:0] in_tdata,
  // tuser: req_type[2:0]
  input  logic [2:0]  in_tuser,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // tdata: status[1:0], step_level[2], enable_level[3], dir_level[4],
  //        moving[5], fault_latched_out[6], move_done[7], fault_flagged[8],
  //        steps_completed[40:9], zero pad [47:41]
  input  logic [47:0] out_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [19:0] cfg_wdata,
  output int unsigned fail_count,
  output int unsigned pending
);
  import stpg_pkg::*;

  // One result as it leaves the block, lowest field last
  typedef struct packed {
    logic [STEPS_W-1:0] completed;
    logic               fault_pulse;
    logic               done_pulse;
    logic               latched;
    logic               moving;
    logic               dir;
    logic               enable;
    logic               step;
    status_t            status;
  } axis_view_t;

  // Register copies and axis state
  logic [TICK_W-1:0]      tick_rate;
  logic [MICRO_W-1:0]     microsteps;
  logic                   running;
  logic                   step_pin;
  logic                   enable_pin;
  logic                   dir_pin;
  logic                   fault_latch;
  logic [STEPS_W-1:0]     target_cnt;
  logic [STEPS_W-1:0]     done_cnt;
  logic [COUNT_WIDTH-1:0] edge_period;
  logic [COUNT_WIDTH-1:0] tick_count;

  axis_view_t  expected_q[$];
  int unsigned errors = 0;

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : track_axis
    axis_view_t  want;
    axis_view_t  seen;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;

    if (!rst_n) begin
      tick_rate   = TICK_W'(100000);
      microsteps  = MICRO_W'(16);
      running     = 1'b0;
      step_pin    = 1'b0;
      enable_pin  = 1'b0;
      dir_pin     = 1'b0;
      fault_latch = 1'b0;
      target_cnt  = '0;
      done_cnt    = '0;
      edge_period = '0;
      tick_count  = '0;
      expected_q.delete();
    end else begin
      // Follow register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_TICK_RATE:  tick_rate  = cfg_wdata;
          CFG_MICROSTEPS: microsteps = cfg_wdata[MICRO_W-1:0];
          default: ;
        endcase
      end

      // Advance the axis on each accepted request
      if (in_tvalid && in_tready) begin
        want = '0;
        case (in_tuser)
          REQ_TICK: begin
            if (running) begin
              tick_count = tick_count + 1'b1;
              if (tick_count >= edge_period) begin
                tick_count = '0;
                if (!step_pin) begin
                  step_pin = 1'b1;
                end else begin
                  // falling edge completes one microstep
                  step_pin = 1'b0;
                  done_cnt = done_cnt + 1'b1;
                  if (done_cnt >= target_cnt) begin
                    running         = 1'b0;
                    enable_pin      = 1'b0;
                    want.done_pulse = 1'b1;
                  end
                end
              end
            end
          end
          REQ_START: begin
            if (running) begin
              want.status = STAT_BUSY;
            end else begin
              if (in_tdata[45]) fault_latch = 1'b1;
              if (fault_latch) begin
                want.status = STAT_FAULT;
              end else begin
                dir_pin    = in_tdata[44];
                target_cnt = in_tdata[31:0];
                done_cnt   = '0;
                tick_count = '0;
                // ticks per edge = rate * 60 / (rpm * microsteps * 2), saturating
                num = 64'(tick_rate) * 64'd60;
                den = 64'(in_tdata[43:32]) * 64'(microsteps) * 64'd2;
                quo = (den == 0) ? '1 : num / den;
                edge_period = (quo > 64'({COUNT_WIDTH{1'b1}})) ? '1 :
                              quo[COUNT_WIDTH-1:0];
                step_pin   = 1'b0;
                enable_pin = 1'b1;
                running    = 1'b1;
              end
            end
          end
          REQ_STOP: begin
            running         = 1'b0;
            step_pin        = 1'b0;
            enable_pin      = 1'b0;
            want.done_pulse = 1'b1;
          end
          REQ_FAULT: begin
            fault_latch      = 1'b1;
            want.fault_pulse = 1'b1;
            if (running) begin
              running         = 1'b0;
              step_pin        = 1'b0;
              enable_pin      = 1'b0;
              want.done_pulse = 1'b1;
            end
          end
          REQ_CLEAR: fault_latch = 1'b0;
          default: ;
        endcase
        want.step      = step_pin;
        want.enable    = enable_pin;
        want.dir       = dir_pin;
        want.moving    = running;
        want.latched   = fault_latch;
        want.completed = done_cnt;
        expected_q.push_back(want);
      end

      // Compare each accepted result against the oldest expectation
      if (out_tvalid && out_tready) begin
        seen = axis_view_t'(out_tdata[40:0]);
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding: tdata %h", out_tdata);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", 64'(want.status), 64'(seen.status));
          check_field("step_level", 64'(want.step), 64'(seen.step));
          check_field("enable_level", 64'(want.enable), 64'(seen.enable));
          check_field("dir_level", 64'(want.dir), 64'(seen.dir));
          check_field("moving", 64'(want.moving), 64'(seen.moving));
          check_field("fault_latched_out", 64'(want.latched), 64'(seen.latched));
          check_field("move_done", 64'(want.done_pulse), 64'(seen.done_pulse));
          check_field("fault_flagged", 64'(want.fault_pulse), 64'(seen.fault_pulse));
          check_field("steps_completed", 64'(want.completed), 64'(seen.completed));
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the step/dir pulse generator testbench: clock, reset, request and
// register stimulus, output back-pressure and the verdict.
// Depends on stpg_pkg, stpg_tb_pkg, stpg_checker and the block itself.
`timescale 1ns / 1ps
module tb_top;
  import stpg_pkg::*;
  import stpg_tb_pkg::*;

  localparam int unsigned COUNT_WIDTH     = 32;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned ITEMS_PER_PHASE = 300;
  localparam int unsigned PHASES          = 6;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic [47:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = REQ_TICK;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_wr_en  = 1'b0;
  logic        cfg_index  = CFG_TICK_RATE;
  logic [19:0] cfg_wdata  = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned accepted    = 0;
  int unsigned burst_left  = 0;
  int unsigned window_left = 0;
  logic [15:0] ready_pattern = 16'hFFFF;

  stepper_step_pulse_generator #(.COUNT_WIDTH(COUNT_WIDTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  stpg_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL stepper_step_pulse_generator");
      $finish;
    end
  end

  // Stall the output on a rotating pattern, renewed every window
  always @(posedge clk) begin
    if (window_left == 0) begin
      window_left   <= $urandom_range(64, 255);
      ready_pattern <= ($urandom_range(3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end else begin
      window_left   <= window_left - 1;
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
    end
    out_tready <= ready_pattern[0];
  end

  function automatic logic [45:0] move_fields(input logic [31:0] steps,
                                              input logic [11:0] rpm,
                                              input logic cw, input logic pin_fault);
    return {pin_fault, cw, rpm, steps};
  endfunction

  // Present one request and hold it until accepted; sometimes idle between bursts
  task automatic send_req(input logic [2:0] kind, input logic [45:0] fields);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, fields};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind <= REQ_CLEAR) accepted++;
  endtask

  // Hold off requests until every expected result is in, then settle
  task automatic drain(input int unsigned settle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [19:0] value);
    cfg_index <= idx;
    cfg_wdata <= value;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned phase_end;
    int unsigned pick;
    int unsigned ticks;
    logic [19:0] rate;
    logic [19:0] micro;
    logic [31:0] steps;
    logic [11:0] rpm;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero period at rate 1, 256 microsteps
    write_reg(CFG_TICK_RATE, 20'd1);
    write_reg(CFG_MICROSTEPS, 20'd256);
    send_req(REQ_TICK, '0);                                    // tick while idle
    send_req(REQ_STOP, '0);                                    // stop while idle
    send_req(3'($urandom_range(5, 7)), '1);                    // unknown request
    send_req(REQ_START, move_fields(32'd0, 12'd4095, 1'b1, 1'b0));
    send_req(REQ_TICK, '0);
    send_req(REQ_START, move_fields('1, 12'd0, 1'b0, 1'b1));   // busy, pin ignored
    send_req(REQ_TICK, '0);                                    // zero target ends here
    send_req(REQ_START, move_fields(32'd2, 12'd1, 1'b0, 1'b0));
    repeat (4) send_req(REQ_TICK, '0);
    send_req(REQ_START, move_fields(32'd5, 12'd100, 1'b1, 1'b1)); // fault at start
    send_req(REQ_START, move_fields(32'd5, 12'd100, 1'b1, 1'b0)); // still latched
    send_req(REQ_CLEAR, '0);
    send_req(REQ_START, move_fields('1, 12'd0, 1'b1, 1'b0));   // zero speed
    send_req(REQ_TICK, '0);
    send_req(REQ_STOP, '0);                                    // stop while moving
    send_req(REQ_START, move_fields(32'd3, 12'd2048, 1'b0, 1'b0));
    send_req(REQ_TICK, '0);
    send_req(REQ_FAULT, '0);                                   // abort a move
    send_req(REQ_FAULT, '0);                                   // fault while idle
    send_req(REQ_CLEAR, '0);
    send_req(3'($urandom_range(5, 7)), '0);

    // Random phases over several register settings
    for (int phase = 0; phase < PHASES; phase++) begin
      drain(SETTLE_CYCLES);
      case (phase)
        0:       begin rate = 20'd1;       micro = 20'd256; end
        1:       begin rate = 20'd1;       micro = 20'd1;   end
        2:       begin rate = 20'd1000000; micro = 20'd256; end
        3:       begin rate = 20'd100000;  micro = 20'd16;  end
        4:       begin rate = 20'd1000;    micro = 20'd8;   end
        default: begin
          rate  = 20'($urandom_range(1, 1000));
          micro = 20'($urandom_range(1, 256));
        end
      endcase
      write_reg(CFG_TICK_RATE, rate);
      write_reg(CFG_MICROSTEPS, micro);
      phase_end = accepted + ITEMS_PER_PHASE;
      while (accepted < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          drain(0);
        end else if (pick < 22) begin
          // noise: any request code, any field content
          repeat ($urandom_range(1, 4))
            send_req(3'($urandom), {1'($urandom), 1'($urandom), 12'($urandom), 32'($urandom)});
        end else begin
          // well-formed move: optional clear, start, then mostly ticks
          if ($urandom_range(1) == 1) send_req(REQ_CLEAR, '0);
          steps = ($urandom_range(9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 4));
          pick  = $urandom_range(19);
          rpm   = (pick == 0) ? 12'd0 :
                  (pick < 10) ? 12'($urandom_range(3840, 4095)) : 12'($urandom_range(1, 4095));
          send_req(REQ_START, move_fields(steps, rpm, 1'($urandom),
                                          $urandom_range(9) == 0));
          ticks = $urandom_range(1, 40);
          repeat (ticks) begin
            pick = $urandom_range(49);
            if (pick == 0) begin
              send_req(REQ_STOP, '0);
            end else if (pick == 1) begin
              send_req(REQ_FAULT, '0);
            end else if (pick == 2) begin
              send_req(REQ_START, move_fields(32'($urandom), 12'($urandom), 1'($urandom),
                                              1'($urandom)));
            end else begin
              send_req(REQ_TICK, '0);
            end
          end
        end
      end
    end

    drain(SETTLE_CYCLES);
    if (fail_count == 0) begin
      $display("PASS stepper_step_pulse_generator");
    end else begin
      $display("FAIL stepper_step_pulse_generator");
    end
    $finish;
  end

endmodule
